// File: hdl/hrt_pkg.sv
// ----------------------------------------------------------------------------
// hrt_pkg
// Shared widths, command codes, register indexes and result type of the
// heater run timer controller.
// ----------------------------------------------------------------------------
package hrt_pkg;

  localparam int REQ_W      = 3;
  localparam int VAL_W      = 10;
  localparam int LEVEL_W    = 2;
  localparam int TGT_W      = 10;
  localparam int SEC_W      = 16;
  localparam int MIN_W      = 10;
  localparam int SUB_W      = 6;
  localparam int FAIL_W     = 8;
  localparam int BAND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int NUM_LEVELS = 3;
  localparam int SEC_PER_MIN = 60;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RUN    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LEVEL  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TIMER  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SENSOR = 3'd4;

  // run state and level command values
  localparam logic [VAL_W-1:0] RUN_STOP  = 10'd0;
  localparam logic [VAL_W-1:0] RUN_START = 10'd1;
  localparam logic [VAL_W-1:0] LEVEL_MAX = 10'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIMER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_THREE  = 3'd4;

  // register reset values
  localparam logic [MIN_W-1:0]  RST_MAX_TIMER  = 10'd60;
  localparam logic [FAIL_W-1:0] RST_FAIL_LIMIT = 8'd3;
  localparam logic [TGT_W-1:0]  RST_TGT_ONE    = 10'd350;
  localparam logic [TGT_W-1:0]  RST_TGT_TWO    = 10'd450;
  localparam logic [TGT_W-1:0]  RST_TGT_THREE  = 10'd550;

  localparam logic [FAIL_W-1:0] FAIL_SAT  = 8'd255;
  localparam logic [SUB_W-1:0]  SUB_LAST  = 6'd59;

  // led band thresholds and codes
  localparam logic [SEC_W-1:0] BAND_MID_SEC = 16'd1800;
  localparam logic [SEC_W-1:0] BAND_LOW_SEC = 16'd600;
  localparam logic [BAND_W-1:0] BAND_NONE  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_TEN   = 2'd1;
  localparam logic [BAND_W-1:0] BAND_THIRTY = 2'd2;
  localparam logic [BAND_W-1:0] BAND_SIXTY = 2'd3;

  typedef struct packed {
    logic              heater_running;
    logic [LEVEL_W-1:0] current_level;
    logic [TGT_W-1:0]  target_tenths;
    logic [SEC_W-1:0]  seconds_left;
    logic [MIN_W-1:0]  minutes_left;
    logic [BAND_W-1:0] time_band;
    logic              status_changed;
    logic              sensor_fault_event;
  } result_t;

  // minutes * 60 as (m << 6) - (m << 2)
  function automatic logic [SEC_W-1:0] to_seconds(input logic [MIN_W-1:0] m);
    logic [SEC_W-1:0] m64;
    logic [SEC_W-1:0] m4;
    m64 = {m, 6'b0};
    m4  = {4'b0, m, 2'b0};
    return m64 - m4;
  endfunction

endpackage

// File: hdl/hrt_in_if.sv
// ----------------------------------------------------------------------------
// hrt_in_if
// Command word channel into the heater run timer controller.
// ----------------------------------------------------------------------------
interface hrt_in_if
  import hrt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [VAL_W-1:0] cmd_value;
  logic             sensor_fault;
  logic             sensor_read_ok;

  modport source (output valid, output req_type, output cmd_value,
                  output sensor_fault, output sensor_read_ok, input ready);
  modport sink   (input valid, input req_type, input cmd_value,
                  input sensor_fault, input sensor_read_ok, output ready);
endinterface

// File: hdl/hrt_out_if.sv
// ----------------------------------------------------------------------------
// hrt_out_if
// Result word channel out of the heater run timer controller.
// ----------------------------------------------------------------------------
interface hrt_out_if
  import hrt_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               heater_running;
  logic [LEVEL_W-1:0] current_level;
  logic [TGT_W-1:0]   target_tenths;
  logic [SEC_W-1:0]   seconds_left;
  logic [MIN_W-1:0]   minutes_left;
  logic [BAND_W-1:0]  time_band;
  logic               status_changed;
  logic               sensor_fault_event;

  modport source (output valid, output heater_running, output current_level,
                  output target_tenths, output seconds_left, output minutes_left,
                  output time_band, output status_changed,
                  output sensor_fault_event, input ready);
  modport sink   (input valid, input heater_running, input current_level,
                  input target_tenths, input seconds_left, input minutes_left,
                  input time_band, input status_changed,
                  input sensor_fault_event, output ready);
endinterface

// File: hdl/hrt_cfg_if.sv
// ----------------------------------------------------------------------------
// hrt_cfg_if
// Register write channel of the heater run timer controller.
// ----------------------------------------------------------------------------
interface hrt_cfg_if
  import hrt_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/heater_run_timer_controller.sv
// ----------------------------------------------------------------------------
// heater_run_timer_controller
// Run state, level, countdown and sensor failure control of a heater.
// ----------------------------------------------------------------------------
// a result word follows its command word through the input register, then
// the result register, and waits there until the output side takes it
// throughput: one command word per cycle, set by the single state update pass,
// while the output side takes its words; a held result stalls the input
// reset: synchronous active low rst_n; clears run state, countdown and fail
// count and loads the register defaults; register writes are always taken
module heater_run_timer_controller
  import hrt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  hrt_in_if.sink    in_ch,
  hrt_out_if.source out_ch,
  hrt_cfg_if.sink   cfg_ch
);

  // configuration registers
  logic [MIN_W-1:0]  max_timer_r;
  logic [FAIL_W-1:0] fail_limit_r;
  logic [TGT_W-1:0]  lvl_tgt_r [NUM_LEVELS];

  // controller state
  logic               running_r,   running_nxt;
  logic [LEVEL_W-1:0] level_r,     level_nxt;
  logic [TGT_W-1:0]   target_r,    target_nxt;
  logic [MIN_W-1:0]   timer_min_r, timer_min_nxt;
  logic [SEC_W-1:0]   rem_sec_r,   rem_sec_nxt;
  logic [MIN_W-1:0]   rem_min_r,   rem_min_nxt;
  logic [SUB_W-1:0]   sub_sec_r,   sub_sec_nxt;
  logic               timing_r,    timing_nxt;
  logic [FAIL_W-1:0]  fail_cnt_r,  fail_cnt_nxt;

  // input register
  logic             s1_vld_r;
  logic [REQ_W-1:0] s1_req_r;
  logic [VAL_W-1:0] s1_val_r;
  logic             s1_fault_r;
  logic             s1_ok_r;

  // result register
  logic    out_vld_r;
  result_t res_r, res_nxt;

  logic             adv;
  logic             halt;
  logic             changed;
  logic             fault_ev;
  logic [SEC_W-1:0] tick_sec;
  logic [FAIL_W-1:0] fail_inc;
  logic [BAND_W-1:0] band;

  assign adv         = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_timer_r  <= RST_MAX_TIMER;
      fail_limit_r <= RST_FAIL_LIMIT;
      lvl_tgt_r[0] <= RST_TGT_ONE;
      lvl_tgt_r[1] <= RST_TGT_TWO;
      lvl_tgt_r[2] <= RST_TGT_THREE;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MAX_TIMER:  max_timer_r  <= cfg_ch.data;
        CFG_FAIL_LIMIT: fail_limit_r <= cfg_ch.data[FAIL_W-1:0];
        CFG_TGT_ONE:    lvl_tgt_r[0] <= cfg_ch.data;
        CFG_TGT_TWO:    lvl_tgt_r[1] <= cfg_ch.data;
        CFG_TGT_THREE:  lvl_tgt_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_req_r   <= in_ch.req_type;
      s1_val_r   <= in_ch.cmd_value;
      s1_fault_r <= in_ch.sensor_fault;
      s1_ok_r    <= in_ch.sensor_read_ok;
    end
  end

  // one state update pass per command word
  always_comb begin
    running_nxt   = running_r;
    level_nxt     = level_r;
    target_nxt    = target_r;
    timer_min_nxt = timer_min_r;
    rem_sec_nxt   = rem_sec_r;
    rem_min_nxt   = rem_min_r;
    sub_sec_nxt   = sub_sec_r;
    timing_nxt    = timing_r;
    fail_cnt_nxt  = fail_cnt_r;
    halt          = 1'b0;
    changed       = 1'b0;
    fault_ev      = 1'b0;
    tick_sec      = (rem_sec_r != '0) ? rem_sec_r - 16'd1 : rem_sec_r;
    fail_inc      = (fail_cnt_r == FAIL_SAT) ? fail_cnt_r : fail_cnt_r + 8'd1;

    unique case (s1_req_r)
      REQ_TICK: begin
        if (running_r && timing_r) begin
          if (tick_sec == '0) begin
            halt    = 1'b1;
            changed = 1'b1;
          end else begin
            rem_sec_nxt = tick_sec;
            // minutes and seconds within the minute follow the countdown
            if (sub_sec_r == '0) begin
              sub_sec_nxt = SUB_LAST;
              rem_min_nxt = rem_min_r - 10'd1;
            end else begin
              sub_sec_nxt = sub_sec_r - 6'd1;
            end
          end
        end
      end
      REQ_RUN: begin
        if (s1_val_r == RUN_STOP) begin
          halt    = 1'b1;
          changed = running_r;
        end else if (s1_val_r == RUN_START && !running_r) begin
          running_nxt = 1'b1;
          changed     = 1'b1;
          if (timer_min_r != '0) begin
            rem_sec_nxt = to_seconds(timer_min_r);
            rem_min_nxt = timer_min_r;
            sub_sec_nxt = '0;
            timing_nxt  = 1'b1;
          end
        end
      end
      REQ_LEVEL: begin
        if (s1_val_r <= LEVEL_MAX) begin
          level_nxt  = s1_val_r[LEVEL_W-1:0];
          target_nxt = lvl_tgt_r[s1_val_r[LEVEL_W-1:0]];
        end
      end
      REQ_TIMER: begin
        if (s1_val_r <= max_timer_r) begin
          timer_min_nxt = s1_val_r;
          timing_nxt    = (s1_val_r != '0);
          rem_sec_nxt   = to_seconds(s1_val_r);
          rem_min_nxt   = s1_val_r;
          sub_sec_nxt   = '0;
        end
      end
      REQ_SENSOR: begin
        if (running_r) begin
          if (s1_fault_r) begin
            halt     = 1'b1;
            changed  = 1'b1;
            fault_ev = 1'b1;
          end else if (!s1_ok_r) begin
            fail_cnt_nxt = fail_inc;
            if (fail_inc >= fail_limit_r) begin
              halt    = 1'b1;
              changed = 1'b1;
            end
          end else begin
            fail_cnt_nxt = '0;
          end
        end
      end
      default: ;
    endcase

    if (halt) begin
      running_nxt   = 1'b0;
      rem_sec_nxt   = '0;
      rem_min_nxt   = '0;
      sub_sec_nxt   = '0;
      timer_min_nxt = '0;
      timing_nxt    = 1'b0;
      fail_cnt_nxt  = '0;
    end
  end

  always_comb begin
    priority if (rem_sec_nxt > BAND_MID_SEC) begin
      band = BAND_SIXTY;
    end else if (rem_sec_nxt > BAND_LOW_SEC) begin
      band = BAND_THIRTY;
    end else if (rem_sec_nxt != '0) begin
      band = BAND_TEN;
    end else begin
      band = BAND_NONE;
    end
  end

  always_comb begin
    res_nxt.heater_running     = running_nxt;
    res_nxt.current_level      = level_nxt;
    res_nxt.target_tenths      = target_nxt;
    res_nxt.seconds_left       = rem_sec_nxt;
    res_nxt.minutes_left       = rem_min_nxt;
    res_nxt.time_band          = band;
    res_nxt.status_changed     = changed;
    res_nxt.sensor_fault_event = fault_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      level_r     <= '0;
      target_r    <= RST_TGT_ONE;
      timer_min_r <= '0;
      rem_sec_r   <= '0;
      rem_min_r   <= '0;
      sub_sec_r   <= '0;
      timing_r    <= 1'b0;
      fail_cnt_r  <= '0;
    end else if (adv) begin
      running_r   <= running_nxt;
      level_r     <= level_nxt;
      target_r    <= target_nxt;
      timer_min_r <= timer_min_nxt;
      rem_sec_r   <= rem_sec_nxt;
      rem_min_r   <= rem_min_nxt;
      sub_sec_r   <= sub_sec_nxt;
      timing_r    <= timing_nxt;
      fail_cnt_r  <= fail_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.heater_running     = res_r.heater_running;
  assign out_ch.current_level      = res_r.current_level;
  assign out_ch.target_tenths      = res_r.target_tenths;
  assign out_ch.seconds_left       = res_r.seconds_left;
  assign out_ch.minutes_left       = res_r.minutes_left;
  assign out_ch.time_band          = res_r.time_band;
  assign out_ch.status_changed     = res_r.status_changed;
  assign out_ch.sensor_fault_event = res_r.sensor_fault_event;

`ifndef SYNTH
  // minute and second counters must track the countdown exactly
  a_count_split: assert property (@(posedge clk) disable iff (!rst_n)
    rem_sec_r == SEC_W'(32'(rem_min_r) * 32'(SEC_PER_MIN) + 32'(sub_sec_r)))
    else $error("countdown minutes and seconds out of step");

  // failures only accumulate while running
  a_fail_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> fail_cnt_r == '0)
    else $error("fail count nonzero while stopped");

  // a fault event is always a stop
  a_fault_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.sensor_fault_event |->
      res_r.status_changed && !res_r.heater_running)
    else $error("fault event without a stop");

  // band is none exactly when no time is left
  a_band_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((res_r.time_band == BAND_NONE) == (res_r.seconds_left == '0)))
    else $error("led band disagrees with remaining time");
`endif

endmodule

// File: bench/heater_run_timer_controller_test.sv
// ----------------------------------------------------------------------------
// heater_run_timer_controller_test
// Self-checking bench for the heater run timer controller. Command words go
// in through a valid/ready channel; a tracker class mirrors run state, level,
// countdown and failed-read count and checks every status word that comes
// out. A short directed sequence comes first, then random command sequences
// under four register settings, with random stalls on both sides and one
// long hold-off on the status side.
// ----------------------------------------------------------------------------
module heater_run_timer_controller_test;
  import hrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 2;
  localparam int HOLD_CYCLES = 48;
  localparam int CYCLE_LIMIT = 200000;

  // mirrors the controller and holds the status words still to come
  class run_status_tracker;
    logic [MIN_W-1:0]   max_minutes;
    logic [FAIL_W-1:0]  fail_limit;
    logic [TGT_W-1:0]   level_target [NUM_LEVELS];
    bit                 running;
    logic [LEVEL_W-1:0] level;
    logic [TGT_W-1:0]   target;
    logic [MIN_W-1:0]   timer_minutes;
    logic [SEC_W-1:0]   remain;
    bit                 counting;
    logic [FAIL_W-1:0]  failed_reads;
    result_t            pending_status [$];
    int                 mismatches;
    int                 checked;
    int                 expiries;
    int                 fault_stops;
    int                 limit_stops;

    function new();
      max_minutes     = RST_MAX_TIMER;
      fail_limit      = RST_FAIL_LIMIT;
      level_target[0] = RST_TGT_ONE;
      level_target[1] = RST_TGT_TWO;
      level_target[2] = RST_TGT_THREE;
      running         = 1'b0;
      level           = '0;
      target          = RST_TGT_ONE;
      timer_minutes   = '0;
      remain          = '0;
      counting        = 1'b0;
      failed_reads    = '0;
      mismatches      = 0;
      checked         = 0;
      expiries        = 0;
      fault_stops     = 0;
      limit_stops     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAX_TIMER:  max_minutes     = data[MIN_W-1:0];
        CFG_FAIL_LIMIT: fail_limit      = data[FAIL_W-1:0];
        CFG_TGT_ONE:    level_target[0] = data[TGT_W-1:0];
        CFG_TGT_TWO:    level_target[1] = data[TGT_W-1:0];
        CFG_TGT_THREE:  level_target[2] = data[TGT_W-1:0];
        default: ;
      endcase
    endfunction

    // stop clears the countdown and failure count, even when already stopped
    function bit halt();
      bit was;
      was           = running;
      running       = 1'b0;
      remain        = '0;
      timer_minutes = '0;
      counting      = 1'b0;
      failed_reads  = '0;
      return was;
    endfunction

    function void note_command(logic [REQ_W-1:0] req, logic [VAL_W-1:0] val,
                               logic fault, logic read_ok);
      result_t st;
      bit      changed;
      bit      fault_ev;
      changed  = 1'b0;
      fault_ev = 1'b0;
      case (req)
        REQ_TICK: begin
          if (running && counting) begin
            if (remain != 0) remain = remain - 1'b1;
            if (remain == 0 && halt()) begin
              changed = 1'b1;
              expiries++;
            end
          end
        end
        REQ_RUN: begin
          if (val == RUN_STOP) begin
            changed = halt();
          end else if (val == RUN_START && !running) begin
            running = 1'b1;
            changed = 1'b1;
            if (timer_minutes != 0) begin
              remain   = SEC_W'(timer_minutes * SEC_PER_MIN);
              counting = 1'b1;
            end
          end
        end
        REQ_LEVEL: begin
          // target is latched from the register now, later writes leave it
          if (val <= LEVEL_MAX) begin
            level  = val[LEVEL_W-1:0];
            target = level_target[val[LEVEL_W-1:0]];
          end
        end
        REQ_TIMER: begin
          if (val <= max_minutes) begin
            timer_minutes = val[MIN_W-1:0];
            counting      = (val != 0);
            remain        = SEC_W'(val * SEC_PER_MIN);
          end
        end
        REQ_SENSOR: begin
          if (running) begin
            if (fault) begin
              void'(halt());
              changed  = 1'b1;
              fault_ev = 1'b1;
              fault_stops++;
            end else if (!read_ok) begin
              if (failed_reads < FAIL_SAT) failed_reads = failed_reads + 1'b1;
              if (failed_reads >= fail_limit) begin
                void'(halt());
                changed = 1'b1;
                limit_stops++;
              end
            end else begin
              failed_reads = '0;
            end
          end
        end
        default: ;
      endcase
      st.heater_running     = running;
      st.current_level      = level;
      st.target_tenths      = target;
      st.seconds_left       = remain;
      st.minutes_left       = MIN_W'(remain / SEC_PER_MIN);
      if (remain > BAND_MID_SEC)      st.time_band = BAND_SIXTY;
      else if (remain > BAND_LOW_SEC) st.time_band = BAND_THIRTY;
      else if (remain != 0)           st.time_band = BAND_TEN;
      else                            st.time_band = BAND_NONE;
      st.status_changed     = changed;
      st.sensor_fault_event = fault_ev;
      pending_status.push_back(st);
    endfunction

    function int pending();
      return pending_status.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_status(result_t got);
      result_t want;
      if (pending_status.size() == 0) begin
        report("status word with no command waiting");
      end else begin
        want = pending_status.pop_front();
        checked++;
        compare("heater_running", 32'(got.heater_running), 32'(want.heater_running));
        compare("current_level", 32'(got.current_level), 32'(want.current_level));
        compare("target_tenths", 32'(got.target_tenths), 32'(want.target_tenths));
        compare("seconds_left", 32'(got.seconds_left), 32'(want.seconds_left));
        compare("minutes_left", 32'(got.minutes_left), 32'(want.minutes_left));
        compare("time_band", 32'(got.time_band), 32'(want.time_band));
        compare("status_changed", 32'(got.status_changed), 32'(want.status_changed));
        compare("sensor_fault_event", 32'(got.sensor_fault_event),
                32'(want.sensor_fault_event));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hrt_in_if  cmd_bus ();
  hrt_out_if status_bus ();
  hrt_cfg_if reg_bus ();

  heater_run_timer_controller i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_bus),
    .out_ch (status_bus),
    .cfg_ch (reg_bus)
  );

  run_status_tracker board = new();

  int sent         = 0;
  int input_stalls = 0;
  int cycles       = 0;
  int settings     = 1;
  bit src_idle     = 1'b1;
  bit sink_stalls  = 1'b1;
  bit hold_due     = 1'b0;
  bit holding      = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // both handshakes sampled at the edge, before any update lands
  always @(posedge clk) begin : watch_words
    result_t got;
    if (rst_n) begin
      if (cmd_bus.valid && cmd_bus.ready)
        board.note_command(cmd_bus.req_type, cmd_bus.cmd_value,
                           cmd_bus.sensor_fault, cmd_bus.sensor_read_ok);
      if (cmd_bus.valid && !cmd_bus.ready) input_stalls++;
      if (status_bus.valid && status_bus.ready) begin
        got.heater_running     = status_bus.heater_running;
        got.current_level      = status_bus.current_level;
        got.target_tenths      = status_bus.target_tenths;
        got.seconds_left       = status_bus.seconds_left;
        got.minutes_left       = status_bus.minutes_left;
        got.time_band          = status_bus.time_band;
        got.status_changed     = status_bus.status_changed;
        got.sensor_fault_event = status_bus.sensor_fault_event;
        board.check_status(got);
      end
    end
  end

  // status side: short random stalls, plus one long hold-off on request
  initial begin : status_sink
    forever begin
      if (hold_due) begin
        hold_due = 1'b0;
        holding  = 1'b1;
        status_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding  = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        status_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        status_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_cmd(logic [REQ_W-1:0] req, logic [VAL_W-1:0] val,
                          logic fault, logic read_ok);
    int gap;
    gap = 0;
    if (src_idle && !holding && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid          <= 1'b1;
    cmd_bus.req_type       <= req;
    cmd_bus.cmd_value      <= val;
    cmd_bus.sensor_fault   <= fault;
    cmd_bus.sensor_read_ok <= read_ok;
    do @(posedge clk); while (!cmd_bus.ready);
    sent++;
  endtask

  // wait until every status word is back and the pipeline is empty
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_settings(logic [CFG_DATA_W-1:0] max_min, logic [CFG_DATA_W-1:0] limit,
                                logic [CFG_DATA_W-1:0] tgt_one, logic [CFG_DATA_W-1:0] tgt_two,
                                logic [CFG_DATA_W-1:0] tgt_three);
    logic [CFG_IDX_W-1:0]  idx_list [5];
    logic [CFG_DATA_W-1:0] data_list [5];
    idx_list  = '{CFG_MAX_TIMER, CFG_FAIL_LIMIT, CFG_TGT_ONE, CFG_TGT_TWO, CFG_TGT_THREE};
    data_list = '{max_min, limit, tgt_one, tgt_two, tgt_three};
    for (int i = 0; i < 5; i++) begin
      reg_bus.valid <= 1'b1;
      reg_bus.index <= idx_list[i];
      reg_bus.data  <= data_list[i];
      do @(posedge clk); while (!reg_bus.ready);
      board.set_reg(idx_list[i], data_list[i]);
    end
    reg_bus.valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [VAL_W-1:0] pick_minutes();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return VAL_W'(1);
      2: return VAL_W'(2);
      3: return VAL_W'(BAND_LOW_SEC / SEC_PER_MIN);
      4: return VAL_W'(BAND_LOW_SEC / SEC_PER_MIN + 1);
      5: return VAL_W'(BAND_MID_SEC / SEC_PER_MIN);
      6: return VAL_W'(BAND_MID_SEC / SEC_PER_MIN + 1);
      7: return VAL_W'(RST_MAX_TIMER);
      8: return VAL_W'(RST_MAX_TIMER + 1);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic directed_cmds();
    send_cmd(REQ_TICK, '0, 1'b0, 1'b0);
    send_cmd('1, '1, 1'b1, 1'b1);                     // undefined request type
    send_cmd(REQ_LEVEL, LEVEL_MAX, 1'b0, 1'b0);
    send_cmd(REQ_LEVEL, LEVEL_MAX + 1'b1, 1'b0, 1'b0);
    send_cmd(REQ_LEVEL, '1, 1'b0, 1'b0);
    send_cmd(REQ_TIMER, VAL_W'(BAND_LOW_SEC / SEC_PER_MIN), 1'b0, 1'b0);
    send_cmd(REQ_TIMER, VAL_W'(BAND_MID_SEC / SEC_PER_MIN), 1'b0, 1'b0);
    send_cmd(REQ_TIMER, VAL_W'(RST_MAX_TIMER + 1), 1'b0, 1'b0);
    send_cmd(REQ_TIMER, VAL_W'(RST_MAX_TIMER), 1'b0, 1'b0);
    send_cmd(REQ_RUN, RUN_START + 1'b1, 1'b0, 1'b0);
    send_cmd(REQ_RUN, RUN_START, 1'b0, 1'b0);
    send_cmd(REQ_RUN, RUN_START, 1'b0, 1'b0);        // already running
    send_cmd(REQ_TICK, '1, 1'b1, 1'b1);
    send_cmd(REQ_SENSOR, '0, 1'b0, 1'b0);
    send_cmd(REQ_SENSOR, '0, 1'b0, 1'b1);           // good read clears the count
    repeat (3) send_cmd(REQ_SENSOR, '0, 1'b0, 1'b0);
    send_cmd(REQ_SENSOR, '0, 1'b1, 1'b0);           // stopped, ignored
    send_cmd(REQ_RUN, RUN_STOP, 1'b0, 1'b0);
    send_cmd(REQ_TIMER, '0, 1'b0, 1'b0);
    send_cmd(REQ_RUN, RUN_START, 1'b0, 1'b0);
    send_cmd(REQ_TICK, '0, 1'b0, 1'b0);             // no countdown without a timer
    send_cmd(REQ_SENSOR, '0, 1'b1, 1'b1);
    send_cmd(REQ_LEVEL, '0, 1'b0, 1'b0);
  endtask

  task automatic random_cmds(int count);
    int stop_at;
    int len;
    stop_at = sent + count;
    while (sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1: send_cmd(REQ_TIMER, pick_minutes(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        2, 3: begin
          case ($urandom_range(0, 7))
            0, 1: send_cmd(REQ_RUN, RUN_STOP, 1'b0, 1'b0);
            2:    send_cmd(REQ_RUN, VAL_W'($urandom), 1'($urandom_range(0, 1)), 1'b1);
            default: send_cmd(REQ_RUN, RUN_START, 1'b0, 1'b0);
          endcase
        end
        4: begin
          if ($urandom_range(0, 3) == 0) send_cmd(REQ_LEVEL, VAL_W'($urandom), 1'b0, 1'b0);
          else send_cmd(REQ_LEVEL, VAL_W'($urandom_range(0, 3)), 1'b0, 1'b0);
        end
        5, 6: begin
          len = $urandom_range(1, 70);
          repeat (len) send_cmd(REQ_TICK, VAL_W'($urandom), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
        end
        7: begin
          len = $urandom_range(1, 6);
          repeat (len) send_cmd(REQ_SENSOR, VAL_W'($urandom), $urandom_range(0, 15) == 0,
                                $urandom_range(0, 3) != 0);
        end
        8: send_cmd(REQ_W'($urandom), VAL_W'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        default: begin
          // a timed run from scratch
          send_cmd(REQ_TIMER, VAL_W'($urandom_range(1, 2)), 1'b0, 1'b0);
          send_cmd(REQ_RUN, RUN_START, 1'b0, 1'b0);
        end
      endcase
    end
  endtask

  initial begin : main
    rst_n                  <= 1'b0;
    cmd_bus.valid          <= 1'b0;
    cmd_bus.req_type       <= '0;
    cmd_bus.cmd_value      <= '0;
    cmd_bus.sensor_fault   <= 1'b0;
    cmd_bus.sensor_read_ok <= 1'b0;
    reg_bus.valid          <= 1'b0;
    reg_bus.index          <= '0;
    reg_bus.data           <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    directed_cmds();
    random_cmds(130);

    settle();
    write_settings(10'd1023, 10'd1, 10'd0, 10'd1023, 10'd512);
    hold_due = 1'b1;
    random_cmds(130);

    settle();
    write_settings(10'd1, 10'd255, 10'd1023, 10'd0, 10'd700);
    random_cmds(130);

    // last stretch runs flat out on both sides
    settle();
    src_idle    = 1'b0;
    sink_stalls = 1'b0;
    write_settings(10'd120, 10'd2, 10'd300, 10'd400, 10'd1000);
    random_cmds(140);

    settle();
    $display("%0d command words sent under %0d register settings, %0d status words checked",
             sent, settings, board.checked);
    $display("stops seen: %0d timer expiries, %0d sensor faults, %0d failed-read limits; %0s %0d",
             board.expiries, board.fault_stops, board.limit_stops,
             "input held off for cycles:", input_stalls);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: heater_run_timer_controller.f
hdl/hrt_pkg.sv
hdl/hrt_in_if.sv
hdl/hrt_out_if.sv
hdl/hrt_cfg_if.sv
hdl/heater_run_timer_controller.sv
bench/heater_run_timer_controller_test.sv
